// ===== rtl/rch_pkg.sv =====
// Package: shared types, constants and helpers for the robot command handler.
`timescale 1ns / 1ps

package rch_pkg;

    // ASCII characters seen in commands
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;

    // Reply frame bytes
    localparam logic [7:0] FRAME_SOF  = 8'h01;
    localparam logic [7:0] FRAME_LEN  = 8'h04;
    localparam logic [7:0] FRAME_PAD  = 8'h00;
    localparam logic [7:0] TYPE_ACK   = 8'h0A;
    localparam logic [7:0] TYPE_ERR   = 8'h0D;

    // Reply command codes
    localparam logic [7:0] CMD_AUTO    = 8'd1;
    localparam logic [7:0] CMD_MANUAL  = 8'd2;
    localparam logic [7:0] CMD_START   = 8'd3;
    localparam logic [7:0] CMD_SPD_UP  = 8'd4;
    localparam logic [7:0] CMD_SPD_DN  = 8'd5;
    localparam logic [7:0] CMD_FWD     = 8'd6;
    localparam logic [7:0] CMD_REV     = 8'd7;
    localparam logic [7:0] CMD_STOP    = 8'd8;
    localparam logic [7:0] CMD_RESET   = 8'd9;
    localparam logic [7:0] CMD_UNKNOWN = 8'd6;
    localparam logic [7:0] CMD_BADGRP  = 8'd8;

    // Speed grades
    localparam logic [7:0] GRADE_MAX   = 8'd10;
    localparam logic [3:0] SPEED_AUTO  = 4'd3;
    localparam logic [7:0] GRADE_START = 8'd10;

    // Timer actions
    localparam logic [1:0] TIMER_NONE    = 2'd0;
    localparam logic [1:0] TIMER_ENABLE  = 2'd1;
    localparam logic [1:0] TIMER_DISABLE = 2'd2;

    // Character positions of a reply
    localparam logic [3:0] LAST_IDX = 4'd13;

    // Work descriptor handed from front to back
    typedef struct packed {
        logic       charge;
        logic [7:0] rtype;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [7:0] sum;
        logic       spw;
        logic [3:0] spv;
        logic [1:0] timer;
        logic       dir;
        logic       hall;
        logic       rst_req;
    } rch_job_t;

    // Nibble to uppercase hex ASCII
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        begin
            if (nib < 4'd10)
                r = CH_ZERO + {4'd0, nib};
            else
                r = 8'd55 + {4'd0, nib};
            return r;
        end
    endfunction

endpackage

// ===== rtl/robot_command_handler.sv =====
// Top level: robot command handler, decode front and reply serializer joined by a queue.
// A command is decoded and written into the queue at its transfer edge; its first result
//   then goes from the queue head into the output register, from which it transfers.
// Throughput: a reply is 14 results, one per cycle from the serializer output register
//   while out_ready is high; charge gives 1, rejected commands none; serializer-paced.
// Input stays open while the queue has room, so commands are taken during serialization.
// Reset clears robot state, queue and output register at once; no clearing pass.
`timescale 1ns / 1ps

module robot_command_handler
    import rch_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] group_char_high,
    input  logic [7:0] group_char_low,
    input  logic [7:0] sub_char_high,
    input  logic [7:0] sub_char_low,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] reply_char,
    output logic       reply_valid,
    output logic       last_of_run,
    output logic       speed_write,
    output logic [3:0] speed_value,
    output logic [1:0] timer_action,
    output logic       direction_pin,
    output logic       hall_mask,
    output logic       reset_request
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    rch_job_t push_job;
    rch_job_t head_job;

    rch_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .group_char_high (group_char_high),
        .group_char_low  (group_char_low),
        .sub_char_high   (sub_char_high),
        .sub_char_low    (sub_char_low),
        .q_full          (q_full),
        .push            (q_push),
        .push_job        (push_job)
    );

    rch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    rch_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_valid),
        .head_job      (head_job),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply_char    (reply_char),
        .reply_valid   (reply_valid),
        .last_of_run   (last_of_run),
        .speed_write   (speed_write),
        .speed_value   (speed_value),
        .timer_action  (timer_action),
        .direction_pin (direction_pin),
        .hall_mask     (hall_mask),
        .reset_request (reset_request)
    );

endmodule

// ===== rtl/rch_front.sv =====
// Front end: decodes commands, updates robot state, posts reply jobs.
`timescale 1ns / 1ps

module rch_front
    import rch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] group_char_high,
    input  logic [7:0] group_char_low,
    input  logic [7:0] sub_char_high,
    input  logic [7:0] sub_char_low,
    input  logic       q_full,
    output logic       push,
    output rch_job_t   push_job
);

    logic       auto_reg, auto_next;
    logic       run_reg, run_next;
    logic [7:0] grade_reg, grade_next;
    logic       fwd_reg, fwd_next;

    logic       accept;
    logic       emit;
    logic       group_ok;
    logic       manual_run;
    logic [7:0] grade_step;
    rch_job_t   job;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Command decode and state update
    always_comb
    begin
        auto_next  = auto_reg;
        run_next   = run_reg;
        grade_next = grade_reg;
        fwd_next   = fwd_reg;
        emit       = 1'b1;
        job        = '0;
        job.rtype  = TYPE_ACK;
        group_ok   = (group_char_high == CH_ZERO) && (group_char_low == CH_A);
        manual_run = !auto_reg && run_reg;
        grade_step = (sub_char_low == CH_FOUR) ? grade_reg - 8'd1 : grade_reg + 8'd1;

        if (!group_ok)
        begin
            job.cmd  = CMD_BADGRP;
            job.data = 8'd2;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_ONE)
        begin
            if (auto_reg)
                emit = 1'b0;
            auto_next = 1'b1;
            run_next  = 1'b1;
            job.cmd   = CMD_AUTO;
            job.data  = 8'd3;
            job.spw   = 1'b1;
            job.spv   = SPEED_AUTO;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_TWO)
        begin
            if (!(auto_reg && run_reg))
            begin
                emit = 1'b0;
            end
            else
            begin
                grade_next = 8'd0;
                auto_next  = 1'b0;
            end
            job.cmd   = CMD_MANUAL;
            job.data  = 8'd2;
            job.timer = TIMER_DISABLE;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_THREE && !auto_reg && !run_reg)
        begin
            run_next   = 1'b1;
            grade_next = GRADE_START;
            job.cmd    = CMD_START;
            job.data   = 8'd1;
            job.timer  = TIMER_ENABLE;
        end
        else if (sub_char_high == CH_ZERO && (sub_char_low == CH_FOUR || sub_char_low == CH_FIVE)
                 && manual_run)
        begin
            grade_next = grade_step;
            emit       = (grade_step >= 8'd1) && (grade_step <= GRADE_MAX);
            job.cmd    = (sub_char_low == CH_FOUR) ? CMD_SPD_UP : CMD_SPD_DN;
            job.data   = GRADE_MAX - grade_step;
            job.spw    = 1'b1;
            job.spv    = grade_step[3:0];
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_SIX && manual_run)
        begin
            fwd_next = 1'b1;
            job.cmd  = CMD_FWD;
            job.data = 8'd1;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_SEVEN && manual_run)
        begin
            fwd_next = 1'b0;
            job.cmd  = CMD_REV;
            job.data = 8'd2;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_EIGHT && manual_run)
        begin
            run_next  = 1'b0;
            job.cmd   = CMD_STOP;
            job.data  = 8'd1;
            job.timer = TIMER_DISABLE;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_NINE)
        begin
            job.cmd     = CMD_RESET;
            job.data    = 8'd1;
            job.rst_req = 1'b1;
        end
        else if (sub_char_high == CH_ZERO && sub_char_low == CH_A)
        begin
            fwd_next   = 1'b1;
            job.charge = 1'b1;
            job.spw    = 1'b1;
            job.spv    = SPEED_AUTO;
            job.hall   = 1'b1;
        end
        else
        begin
            job.rtype = TYPE_ERR;
            job.cmd   = CMD_UNKNOWN;
            job.data  = 8'd1;
        end

        job.dir = fwd_next;
        job.sum = FRAME_SOF + job.rtype + job.cmd + FRAME_LEN + FRAME_PAD + job.data;
    end

    assign push     = accept && emit;
    assign push_job = job;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg  <= 1'b0;
            run_reg   <= 1'b0;
            grade_reg <= 8'd0;
            fwd_reg   <= 1'b0;
        end
        else if (accept)
        begin
            auto_reg  <= auto_next;
            run_reg   <= run_next;
            grade_reg <= grade_next;
            fwd_reg   <= fwd_next;
        end
    end

endmodule

// ===== rtl/rch_queue.sv =====
// Job queue between decode front and reply back end.
`timescale 1ns / 1ps

module rch_queue
    import rch_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rch_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output rch_job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    rch_job_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/rch_back.sv =====
// Back end: serializes reply jobs into hex characters through an output register.
`timescale 1ns / 1ps

module rch_back
    import rch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  rch_job_t   head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] reply_char,
    output logic       reply_valid,
    output logic       last_of_run,
    output logic       speed_write,
    output logic [3:0] speed_value,
    output logic [1:0] timer_action,
    output logic       direction_pin,
    output logic       hall_mask,
    output logic       reset_request
);

    rch_job_t   job_reg;
    logic       busy_reg;
    logic [3:0] idx_reg;

    logic       ov_reg;
    logic [7:0] char_reg;
    logic       rv_reg, last_reg, spw_reg, dir_reg, hall_reg, rst_reg;
    logic [3:0] spv_reg;
    logic [1:0] tmr_reg;

    rch_job_t   cur;
    logic       have;
    logic       produce;
    logic       is_first;
    logic       is_last;
    logic [7:0] cur_byte;
    logic [7:0] chr;

    assign cur      = busy_reg ? job_reg : head_job;
    assign have     = busy_reg || head_valid;
    assign produce  = have && (!ov_reg || out_ready);
    assign is_first = !busy_reg;
    assign is_last  = cur.charge || (idx_reg == LAST_IDX);
    assign pop      = produce && !busy_reg;

    // Frame byte select
    always_comb
    begin
        case (idx_reg[3:1])
            3'd0:    cur_byte = FRAME_SOF;
            3'd1:    cur_byte = cur.rtype;
            3'd2:    cur_byte = cur.cmd;
            3'd3:    cur_byte = FRAME_LEN;
            3'd4:    cur_byte = FRAME_PAD;
            3'd5:    cur_byte = cur.data;
            3'd6:    cur_byte = cur.sum;
            default: cur_byte = FRAME_PAD;
        endcase
        chr = idx_reg[0] ? hex_char(cur_byte[3:0]) : hex_char(cur_byte[7:4]);
    end

    // Job tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (produce)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                busy_reg <= 1'b1;
                idx_reg  <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (produce)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            char_reg <= cur.charge ? 8'd0 : chr;
            rv_reg   <= !cur.charge;
            last_reg <= is_last;
            spw_reg  <= is_first && cur.spw;
            spv_reg  <= (is_first && cur.spw) ? cur.spv : 4'd0;
            tmr_reg  <= is_first ? cur.timer : TIMER_NONE;
            dir_reg  <= cur.dir;
            hall_reg <= is_first && cur.hall;
            rst_reg  <= is_last && cur.rst_req;
        end
    end

    assign out_valid     = ov_reg;
    assign reply_char    = char_reg;
    assign reply_valid   = rv_reg;
    assign last_of_run   = last_reg;
    assign speed_write   = spw_reg;
    assign speed_value   = spv_reg;
    assign timer_action  = tmr_reg;
    assign direction_pin = dir_reg;
    assign hall_mask     = hall_reg;
    assign reset_request = rst_reg;

    // A job in flight has already sent its first character
    a_busy_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg != 4'd0))
        else $error("busy with character index zero");

    // Only the charge result carries no reply character
    a_charge: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !rv_reg) |-> (last_reg && hall_reg && spw_reg))
        else $error("non-reply result is not a charge result");

    // Reset request rides only on the closing character
    a_rst_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && rst_reg) |-> last_reg)
        else $error("reset request before end of reply");

    // Pull from the queue only when not mid-job
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head_valid && !busy_reg))
        else $error("queue pop while busy or empty");

endmodule

// ===== tb/sv/tb_robot_command_handler.sv =====
// Testbench for robot_command_handler: directed table plus random commands, scoreboarded.
`timescale 1ns / 1ps

module tb_robot_command_handler;

    import rch_pkg::*;

    localparam int REPLY_CHARS   = 14;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_CMDS   = 145;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_NS   = 2_000_000;

    // Replies that can be read straight off the frame layout
    localparam string TXT_BADGRP  = "010A0804000219";
    localparam string TXT_UNKNOWN = "010D0604000119";
    localparam string TXT_START   = "010A0304000113";
    localparam string TXT_AUTO    = "010A0104000313";
    localparam string TXT_RESET   = "010A0904000119";

    typedef struct packed {
        logic [7:0] g_hi;
        logic [7:0] g_lo;
        logic [7:0] s_hi;
        logic [7:0] s_lo;
    } cmd_chars_t;

    // One output character of a reply, with its side-band fields
    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       last;
        logic       spw;
        logic [3:0] spv;
        logic [1:0] timer;
        logic       dir;
        logic       hall;
        logic       rst_req;
    } reply_beat_t;

    typedef reply_beat_t reply_run_t [REPLY_CHARS];

    typedef struct {
        cmd_chars_t cmd;
        string      typed;
    } directed_row_t;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

    localparam logic [7:0] SUB_CODES [10] = '{CH_ONE, CH_TWO, CH_THREE, CH_FOUR, CH_FIVE,
                                              CH_SIX, CH_SEVEN, CH_EIGHT, CH_NINE, CH_A};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] group_char_high = 8'h00;
    logic [7:0] group_char_low = 8'h00;
    logic [7:0] sub_char_high = 8'h00;
    logic [7:0] sub_char_low = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] reply_char;
    logic       reply_valid;
    logic       last_of_run;
    logic       speed_write;
    logic [3:0] speed_value;
    logic [1:0] timer_action;
    logic       direction_pin;
    logic       hall_mask;
    logic       reset_request;

    // Mirror of the robot state
    logic       st_auto = 1'b0;
    logic       st_running = 1'b0;
    logic [7:0] st_grade = 8'd0;
    logic       st_forward = 1'b0;

    reply_beat_t expected_beats [$];
    reply_beat_t want_beat;
    int          mismatch_count = 0;
    int          beats_checked = 0;
    int          commands_sent = 0;
    int          silent_commands = 0;
    int          burst_left = 0;

    rx_mode_t    rx_mode = RX_STEADY;
    int          rx_mode_left = 0;
    int          rx_phase = 0;
    logic [7:0]  rx_pattern = 8'hFF;

    // Directed walk from reset; typed text where the reply is obvious
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{8'h00, 8'h00, 8'h00, 8'h00}, TXT_BADGRP},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, TXT_BADGRP},
        '{'{CH_ZERO, 8'h42, CH_ZERO, CH_ONE}, TXT_BADGRP},
        '{'{CH_ZERO, CH_A, 8'hFF, 8'h00}, TXT_UNKNOWN},
        '{'{CH_ZERO, CH_A, CH_ZERO, 8'hFF}, TXT_UNKNOWN},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FOUR}, TXT_UNKNOWN},   // speed up while idle
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_TWO}, ""},             // manual outside auto: silent
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_THREE}, TXT_START},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_THREE}, TXT_UNKNOWN},  // start while running
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FIVE}, ""},            // grade 11: silent
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FOUR}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FOUR}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_SIX}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_SEVEN}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_EIGHT}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_EIGHT}, TXT_UNKNOWN},  // stop while stopped
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_ONE}, TXT_AUTO},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_ONE}, ""},             // auto twice: silent
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_NINE}, TXT_RESET},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_TWO}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FOUR}, ""},            // grade wraps to 255
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FIVE}, ""},            // back to 0, still silent
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_FIVE}, ""},
        '{'{CH_ZERO, CH_A, CH_ZERO, CH_A}, ""},               // charge
        '{'{CH_ZERO, CH_A, CH_ONE, CH_ONE}, TXT_UNKNOWN}
    };

    robot_command_handler DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .group_char_high(group_char_high),
        .group_char_low (group_char_low),
        .sub_char_high  (sub_char_high),
        .sub_char_low   (sub_char_low),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reply_char     (reply_char),
        .reply_valid    (reply_valid),
        .last_of_run    (last_of_run),
        .speed_write    (speed_write),
        .speed_value    (speed_value),
        .timer_action   (timer_action),
        .direction_pin  (direction_pin),
        .hall_mask      (hall_mask),
        .reset_request  (reset_request)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the state mirror and build the reply it causes
    function automatic int predict_command(input cmd_chars_t cmd, output reply_run_t run);
        int         n;
        int         i;
        logic       manual_run;
        logic       charge;
        logic       spw;
        logic [3:0] spv;
        logic [1:0] timer;
        logic       rst_req;
        logic [7:0] rtype;
        logic [7:0] rcmd;
        logic [7:0] rdata;
        logic [7:0] frame [7];
        logic [3:0] nib;

        n = REPLY_CHARS;
        charge = 1'b0;
        spw = 1'b0;
        spv = 4'd0;
        timer = TIMER_NONE;
        rst_req = 1'b0;
        rtype = TYPE_ACK;
        rcmd = CMD_BADGRP;
        rdata = 8'd2;
        manual_run = !st_auto && st_running;
        for (i = 0; i < REPLY_CHARS; i++)
            run[i] = '0;

        if (cmd.g_hi != CH_ZERO || cmd.g_lo != CH_A)
        begin
            // wrong group: fixed bad-group reply, state untouched
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_ONE)
        begin
            if (st_auto)
                n = 0;
            else
            begin
                st_auto = 1'b1;
                st_running = 1'b1;
                rcmd = CMD_AUTO;
                rdata = 8'd3;
                spw = 1'b1;
                spv = SPEED_AUTO;
            end
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_TWO)
        begin
            if (!(st_auto && st_running))
                n = 0;
            else
            begin
                st_grade = 8'd0;
                st_auto = 1'b0;
                rcmd = CMD_MANUAL;
                rdata = 8'd2;
                timer = TIMER_DISABLE;
            end
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_THREE && !st_auto && !st_running)
        begin
            st_running = 1'b1;
            st_grade = GRADE_START;
            rcmd = CMD_START;
            rdata = 8'd1;
            timer = TIMER_ENABLE;
        end
        else if (cmd.s_hi == CH_ZERO && (cmd.s_lo == CH_FOUR || cmd.s_lo == CH_FIVE)
                 && manual_run)
        begin
            // grade change sticks even when out of range
            st_grade = (cmd.s_lo == CH_FOUR) ? st_grade - 8'd1 : st_grade + 8'd1;
            if (st_grade < 8'd1 || st_grade > GRADE_MAX)
                n = 0;
            else
            begin
                rcmd = (cmd.s_lo == CH_FOUR) ? CMD_SPD_UP : CMD_SPD_DN;
                rdata = GRADE_MAX - st_grade;
                spw = 1'b1;
                spv = st_grade[3:0];
            end
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_SIX && manual_run)
        begin
            st_forward = 1'b1;
            rcmd = CMD_FWD;
            rdata = 8'd1;
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_SEVEN && manual_run)
        begin
            st_forward = 1'b0;
            rcmd = CMD_REV;
            rdata = 8'd2;
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_EIGHT && manual_run)
        begin
            st_running = 1'b0;
            rcmd = CMD_STOP;
            rdata = 8'd1;
            timer = TIMER_DISABLE;
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_NINE)
        begin
            rcmd = CMD_RESET;
            rdata = 8'd1;
            rst_req = 1'b1;
        end
        else if (cmd.s_hi == CH_ZERO && cmd.s_lo == CH_A)
        begin
            st_forward = 1'b1;
            charge = 1'b1;
            spw = 1'b1;
            spv = SPEED_AUTO;
            n = 1;
        end
        else
        begin
            rtype = TYPE_ERR;
            rcmd = CMD_UNKNOWN;
            rdata = 8'd1;
        end

        // Serialize the frame as hex text, high nibble first
        if (n == REPLY_CHARS)
        begin
            frame[0] = FRAME_SOF;
            frame[1] = rtype;
            frame[2] = rcmd;
            frame[3] = FRAME_LEN;
            frame[4] = FRAME_PAD;
            frame[5] = rdata;
            frame[6] = 8'd0;
            for (i = 0; i < 6; i++)
                frame[6] = frame[6] + frame[i];
            for (i = 0; i < REPLY_CHARS; i++)
            begin
                nib = i[0] ? frame[i / 2][3:0] : frame[i / 2][7:4];
                run[i].ch = (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10;
                run[i].vld = 1'b1;
            end
            run[REPLY_CHARS - 1].last = 1'b1;
            run[REPLY_CHARS - 1].rst_req = rst_req;
        end
        else if (charge)
        begin
            run[0].last = 1'b1;
            run[0].hall = 1'b1;
        end
        if (n > 0)
        begin
            run[0].spw = spw;
            run[0].spv = spv;
            run[0].timer = timer;
        end
        for (i = 0; i < n; i++)
            run[i].dir = st_forward;
        return n;
    endfunction

    // Mostly well-formed commands; some broken groups, prefixes and raw noise
    function automatic cmd_chars_t random_command();
        cmd_chars_t cmd;
        int         pick;

        pick = $urandom_range(0, 99);
        if (pick < 8)
            cmd = cmd_chars_t'($urandom);
        else
        begin
            cmd.g_hi = CH_ZERO;
            cmd.g_lo = CH_A;
            if (pick < 13)
            begin
                if ($urandom_range(0, 1) == 0)
                    cmd.g_hi = 8'($urandom);
                else
                    cmd.g_lo = 8'($urandom);
            end
            cmd.s_hi = ($urandom_range(0, 19) == 0) ? 8'($urandom) : CH_ZERO;
            cmd.s_lo = ($urandom_range(0, 14) == 0) ? 8'($urandom)
                                                    : SUB_CODES[$urandom_range(0, 9)];
        end
        return cmd;
    endfunction

    // Drive one command, wait for its transfer, queue the expected reply
    task automatic issue_command(input cmd_chars_t cmd, input string typed);
        reply_run_t run;
        int         n;
        int         i;
        int         gap;

        in_valid <= 1'b1;
        group_char_high <= cmd.g_hi;
        group_char_low <= cmd.g_lo;
        sub_char_high <= cmd.s_hi;
        sub_char_low <= cmd.s_lo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        n = predict_command(cmd, run);
        if (typed.len() == REPLY_CHARS)
        begin
            n = REPLY_CHARS;
            for (i = 0; i < REPLY_CHARS; i++)
            begin
                run[i].ch = typed[i];
                run[i].vld = 1'b1;
                run[i].last = (i == REPLY_CHARS - 1);
            end
        end
        for (i = 0; i < n; i++)
            expected_beats.push_back(run[i]);
        commands_sent++;
        if (n == 0)
            silent_commands++;

        // Sender bursts: back-to-back transfers, then an idle gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 11);
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver: steady, random or repeating-pattern ready, switching between modes at random
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
            rx_pattern = 8'($urandom) | 8'h01;
        end
        rx_mode_left--;
        rx_phase = (rx_phase + 1) % 8;
        case (rx_mode)
            RX_STEADY:  out_ready <= 1'b1;
            RX_RANDOM:  out_ready <= ($urandom_range(0, 9) < 6);
            default:    out_ready <= rx_pattern[rx_phase];
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual char %0h", $time,
                         reply_char);
                mismatch_count++;
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                check_field("reply_char", want_beat.ch, reply_char);
                check_field("reply_valid", want_beat.vld, reply_valid);
                check_field("last_of_run", want_beat.last, last_of_run);
                check_field("speed_write", want_beat.spw, speed_write);
                check_field("speed_value", want_beat.spv, speed_value);
                check_field("timer_action", want_beat.timer, timer_action);
                check_field("direction_pin", want_beat.dir, direction_pin);
                check_field("hall_mask", want_beat.hall, hall_mask);
                check_field("reset_request", want_beat.rst_req, reset_request);
                beats_checked++;
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            issue_command(directed_rows[i].cmd, directed_rows[i].typed);
        for (i = 0; i < RANDOM_CMDS; i++)
            issue_command(random_command(), "");
        in_valid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d directed, %0d with no reply).", commands_sent,
                 DIRECTED_ROWS, silent_commands);
        $display("Checked %0d reply characters under random sender gaps and receiver stalls.",
                 beats_checked);
        if (mismatch_count == 0)
            $display("[robot_command_handler] OK");
        else
            $display("[robot_command_handler] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timeout with %0d results still expected.", expected_beats.size());
        $display("[robot_command_handler] ERROR");
        $finish;
    end

endmodule
